// ===== rtl/rlfb_pkg.sv =====
// Shared types, constants and the log brightness table of the RGB fade/blink sequencer.
package rlfb_pkg;

  // Mode register codes
  localparam logic [1:0] MODE_OFF       = 2'd0;
  localparam logic [1:0] MODE_BLINK     = 2'd1;
  localparam logic [1:0] MODE_FADE_EYE  = 2'd2;
  localparam logic [1:0] MODE_FADE      = 2'd3;

  // Eye LED codes
  localparam logic [1:0] EYE_OFF   = 2'd0;
  localparam logic [1:0] EYE_BLUE  = 2'd1;
  localparam logic [1:0] EYE_GREEN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE           = 2'd0;
  localparam logic [1:0] REG_BLINK_INTERVAL = 2'd1;
  localparam logic [1:0] REG_FADE_INTERVAL  = 2'd2;

  localparam logic [5:0]  TOP_INDEX   = 6'd40;
  localparam logic [5:0]  FALL_START  = 6'd41;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [15:0] BLINK_RESET = 16'd4500;
  localparam logic [15:0] FADE_RESET  = 16'd200;

  // Fade position and PWM levels of the three channels (0 red, 1 green, 2 blue)
  typedef struct packed {
    logic [2:0][5:0] rise;
    logic [2:0][5:0] fall;
    logic [2:0][9:0] pwm;
  } fade_state_t;

  // Outcome of one fade step
  typedef struct packed {
    fade_state_t st;
    logic        eye_wr;
    logic [1:0]  eye;
  } fade_res_t;

  // One result transaction
  typedef struct packed {
    logic [9:0] red_level;
    logic [9:0] green_level;
    logic [9:0] blue_level;
    logic [1:0] eye_color;
    logic       stepped;
  } result_t;

  // Logarithmic brightness table, indexes above the top clamp to full scale
  function automatic logic [9:0] log_level(input logic [5:0] idx);
    logic [9:0] v;
    case (idx)
      6'd0:  v = 10'd1;
      6'd1:  v = 10'd1;
      6'd2:  v = 10'd1;
      6'd3:  v = 10'd2;
      6'd4:  v = 10'd2;
      6'd5:  v = 10'd2;
      6'd6:  v = 10'd3;
      6'd7:  v = 10'd3;
      6'd8:  v = 10'd4;
      6'd9:  v = 10'd5;
      6'd10: v = 10'd6;
      6'd11: v = 10'd7;
      6'd12: v = 10'd8;
      6'd13: v = 10'd10;
      6'd14: v = 10'd11;
      6'd15: v = 10'd13;
      6'd16: v = 10'd16;
      6'd17: v = 10'd19;
      6'd18: v = 10'd23;
      6'd19: v = 10'd27;
      6'd20: v = 10'd32;
      6'd21: v = 10'd38;
      6'd22: v = 10'd45;
      6'd23: v = 10'd54;
      6'd24: v = 10'd64;
      6'd25: v = 10'd76;
      6'd26: v = 10'd90;
      6'd27: v = 10'd108;
      6'd28: v = 10'd128;
      6'd29: v = 10'd152;
      6'd30: v = 10'd181;
      6'd31: v = 10'd215;
      6'd32: v = 10'd256;
      6'd33: v = 10'd304;
      6'd34: v = 10'd362;
      6'd35: v = 10'd430;
      6'd36: v = 10'd512;
      6'd37: v = 10'd608;
      6'd38: v = 10'd723;
      6'd39: v = 10'd860;
      default: v = 10'd1023;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/rlfb_fade.sv =====
// Combinational fade step: advances the first unfinished channel or rewraps all.
module rlfb_fade (
  input  rlfb_pkg::fade_state_t cur_i,
  input  logic                  eye_colors_i,
  output rlfb_pkg::fade_res_t   res_o
);
  import rlfb_pkg::*;

  always_comb begin
    logic       done;
    logic [5:0] idx;
    done         = 1'b0;
    idx          = '0;
    res_o.st     = cur_i;
    res_o.eye_wr = 1'b0;
    res_o.eye    = EYE_OFF;
    // channels in order: rise first, then fall
    for (int ch = 0; ch < 3; ch++) begin
      if (!done) begin
        if (cur_i.rise[ch] < TOP_INDEX) begin
          idx               = cur_i.rise[ch] + 6'd1;
          res_o.st.rise[ch] = idx;
          res_o.st.pwm[ch]  = log_level(idx);
          if (eye_colors_i && ch == 1) begin
            res_o.eye_wr = 1'b1;
            res_o.eye    = EYE_BLUE;
          end
          if (eye_colors_i && ch == 2) begin
            res_o.eye_wr = 1'b1;
            res_o.eye    = EYE_GREEN;
          end
          done = 1'b1;
        end else if (cur_i.fall[ch] != 6'd0) begin
          idx               = cur_i.fall[ch] - 6'd1;
          res_o.st.fall[ch] = idx;
          res_o.st.pwm[ch]  = log_level(idx);
          done = 1'b1;
        end
      end
    end
    // all channels done: restart the cycle, levels kept
    if (!done) begin
      for (int ch = 0; ch < 3; ch++) begin
        res_o.st.rise[ch] = 6'd0;
        res_o.st.fall[ch] = FALL_START;
      end
    end
  end

endmodule

// ===== rtl/rlfb_core.sv =====
// Sequencer state: configuration, tick counter, blink phase, fade position, eye LED.
module rlfb_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                step_en_i,
  input  logic                tick_i,
  output rlfb_pkg::result_t   res_o
);
  import rlfb_pkg::*;

  logic [1:0]  mode_r;
  logic [15:0] blink_int_r;
  logic [15:0] fade_int_r;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic        blink_phase_r, blink_phase_nxt;
  fade_state_t fade_r, fade_nxt;
  logic [1:0]  eye_r, eye_nxt;

  logic        active;
  logic        fire;
  logic [15:0] interval;
  logic [15:0] cnt_inc;
  fade_res_t   fade_res;

  rlfb_fade u_fade (
    .cur_i        (fade_r),
    .eye_colors_i (mode_r == MODE_FADE_EYE),
    .res_o        (fade_res)
  );

  // tick counting against the interval of the current mode
  always_comb begin
    active   = tick_i && (mode_r != MODE_OFF);
    interval = (mode_r == MODE_BLINK) ? blink_int_r : fade_int_r;
    cnt_inc  = (tick_count_r == COUNT_MAX) ? COUNT_MAX : tick_count_r + 16'd1;
    fire     = active && (cnt_inc >= interval);
  end

  // next state for this transaction
  always_comb begin
    tick_count_nxt  = tick_count_r;
    blink_phase_nxt = blink_phase_r;
    fade_nxt        = fade_r;
    eye_nxt         = eye_r;
    if (active) begin
      tick_count_nxt = fire ? 16'd0 : cnt_inc;
    end
    if (fire) begin
      if (mode_r == MODE_BLINK) begin
        eye_nxt         = blink_phase_r ? EYE_BLUE : EYE_GREEN;
        blink_phase_nxt = ~blink_phase_r;
      end else begin
        fade_nxt = fade_res.st;
        if (fade_res.eye_wr) begin
          eye_nxt = fade_res.eye;
        end
      end
    end
  end

  assign res_o.red_level   = fade_nxt.pwm[0];
  assign res_o.green_level = fade_nxt.pwm[1];
  assign res_o.blue_level  = fade_nxt.pwm[2];
  assign res_o.eye_color   = eye_nxt;
  assign res_o.stepped     = fire;

  // state registers; configuration writes take priority
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_OFF;
      blink_int_r   <= BLINK_RESET;
      fade_int_r    <= FADE_RESET;
      tick_count_r  <= COUNT_MAX;
      blink_phase_r <= 1'b0;
      for (int ch = 0; ch < 3; ch++) begin
        fade_r.rise[ch] <= 6'd0;
        fade_r.fall[ch] <= FALL_START;
        fade_r.pwm[ch]  <= 10'd0;
      end
      eye_r <= EYE_OFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE: begin
          mode_r       <= cfg_data_i[1:0];
          tick_count_r <= COUNT_MAX;
          if (cfg_data_i[1:0] == MODE_OFF) begin
            eye_r <= EYE_OFF;
          end
        end
        REG_BLINK_INTERVAL: blink_int_r <= cfg_data_i;
        REG_FADE_INTERVAL:  fade_int_r  <= cfg_data_i;
        default: ;
      endcase
    end else if (step_en_i) begin
      tick_count_r  <= tick_count_nxt;
      blink_phase_r <= blink_phase_nxt;
      fade_r        <= fade_nxt;
      eye_r         <= eye_nxt;
    end
  end

  a_step_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> tick_i && mode_r != MODE_OFF)
    else $error("step without tick or in off mode");

  a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step_en_i && fire && !cfg_we_i |=> tick_count_r == 16'd0)
    else $error("tick count not restarted after step");

  a_eye_code: assert property (@(posedge clk) disable iff (!rst_n)
    eye_r == EYE_OFF || eye_r == EYE_BLUE || eye_r == EYE_GREEN)
    else $error("eye state holds an unused code");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    fade_r.rise[0] <= TOP_INDEX && fade_r.rise[1] <= TOP_INDEX &&
    fade_r.rise[2] <= TOP_INDEX && fade_r.fall[0] <= FALL_START &&
    fade_r.fall[1] <= FALL_START && fade_r.fall[2] <= FALL_START)
    else $error("fade index out of range");

endmodule

// ===== rtl/rgb_log_fade_blink_sequencer.sv =====
// Top level of the RGB log fade / eye blink sequencer: input register, core, result register.
//
// Usage:
//   Input channel (in_valid, in_stall, in_tick): one transaction per clock at most;
//   in_tick = 1 marks a timer base tick, 0 an idle cycle. Every input transaction
//   yields exactly one result transaction, in order.
//   Result channel (out_valid, out_stall, out_*): PWM compare levels of the three
//   channels, the eye LED code and a flag that the transaction took a sequencer step.
//   Configuration (cfg_we, cfg_index, cfg_data): 0 mode, 1 blink interval,
//   2 fade interval; write only while no transaction is in flight. A mode write
//   makes the next tick step; index 3 is ignored.
//   Each transaction passes the input register, then the result register, and a
//   stall on the result side can hold it in either.
//   Throughput: one transaction per cycle while the receiver does not stall, set by
//   the combinational state update between the two registers.
//   Reset (rst_n low, synchronous): both registers empty, mode off, intervals
//   4500 and 200, levels zero, eye off, next tick steps.
//   Receiver stall: the result register holds; in_stall rises only once the input
//   register is also full, so one more transaction is taken under a stall.
module rgb_log_fade_blink_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_red_level,
  output logic [9:0]  out_green_level,
  output logic [9:0]  out_blue_level,
  output logic [1:0]  out_eye_color,
  output logic        out_stepped,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rlfb_pkg::*;

  logic    s1_valid_r;
  logic    s1_tick_r;
  logic    out_valid_r;
  result_t out_r;
  result_t core_res;
  logic    advance;

  // pipeline moves when the result register is free or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  rlfb_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .step_en_i   (s1_valid_r && advance),
    .tick_i      (s1_tick_r),
    .res_o       (core_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_tick_r <= in_tick;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_r <= core_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = out_r.red_level;
  assign out_green_level = out_r.green_level;
  assign out_blue_level  = out_r.blue_level;
  assign out_eye_color   = out_r.eye_color;
  assign out_stepped     = out_r.stepped;

endmodule

// ===== tb/sv/fade_blink_checker.sv =====
// Result checker for the RGB fade/blink sequencer: tracks its state, predicts and compares.
`timescale 1ns / 100ps
module fade_blink_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_tick,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  out_red_level,
  input  logic [9:0]  out_green_level,
  input  logic [9:0]  out_blue_level,
  input  logic [1:0]  out_eye_color,
  input  logic        out_stepped,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);
  import rlfb_pkg::*;

  // Log brightness curve, index 0 first
  localparam logic [0:40][9:0] BRIGHTNESS = {
    10'd1,
    10'd1,   10'd1,   10'd2,   10'd2,   10'd2,   10'd3,   10'd3,   10'd4,   10'd5,   10'd6,
    10'd7,   10'd8,   10'd10,  10'd11,  10'd13,  10'd16,  10'd19,  10'd23,  10'd27,  10'd32,
    10'd38,  10'd45,  10'd54,  10'd64,  10'd76,  10'd90,  10'd108, 10'd128, 10'd152, 10'd181,
    10'd215, 10'd256, 10'd304, 10'd362, 10'd430, 10'd512, 10'd608, 10'd723, 10'd860, 10'd1023
  };

  // Shadow copy of registers and sequencer state
  logic [1:0]  mode_r;
  logic [15:0] blink_iv;
  logic [15:0] fade_iv;
  logic [15:0] tick_cnt;
  logic        blink_ph;
  logic [5:0]  rise_ix [3];
  logic [5:0]  fall_ix [3];
  logic [9:0]  level [3];
  logic [1:0]  eye;

  // Expected result transactions, oldest first
  result_t     levels_due [$];
  int          fail_count = 0;

  assign errors = fail_count;

  function automatic logic [9:0] brightness_at(input logic [5:0] idx);
    return (idx > TOP_INDEX) ? BRIGHTNESS[TOP_INDEX] : BRIGHTNESS[idx];
  endfunction

  task automatic clear_state();
    mode_r   = MODE_OFF;
    blink_iv = BLINK_RESET;
    fade_iv  = FADE_RESET;
    tick_cnt = COUNT_MAX;
    blink_ph = 1'b0;
    eye      = EYE_OFF;
    for (int ch = 0; ch < 3; ch++) begin
      rise_ix[ch] = '0;
      fall_ix[ch] = FALL_START;
      level[ch]   = '0;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    case (idx)
      REG_MODE: begin
        mode_r   = val[1:0];
        tick_cnt = COUNT_MAX;  // next tick steps
        if (val[1:0] == MODE_OFF) eye = EYE_OFF;
      end
      REG_BLINK_INTERVAL: blink_iv = val;
      REG_FADE_INTERVAL:  fade_iv = val;
      default: ;
    endcase
  endtask

  // One breathing step: the first channel not yet through, rising before falling
  task automatic advance_fade(input logic eye_on);
    for (int ch = 0; ch < 3; ch++) begin
      if (rise_ix[ch] < TOP_INDEX) begin
        rise_ix[ch] = rise_ix[ch] + 6'd1;
        level[ch]   = brightness_at(rise_ix[ch]);
        if (eye_on && ch == 1) eye = EYE_BLUE;
        if (eye_on && ch == 2) eye = EYE_GREEN;
        return;
      end
      if (fall_ix[ch] > 6'd0) begin
        fall_ix[ch] = fall_ix[ch] - 6'd1;
        level[ch]   = brightness_at(fall_ix[ch]);
        return;
      end
    end
    // all channels done: rewind the cycle, levels stay
    for (int ch = 0; ch < 3; ch++) begin
      rise_ix[ch] = '0;
      fall_ix[ch] = FALL_START;
    end
  endtask

  task automatic take_tick(input logic tick, output result_t r);
    logic [16:0] next_cnt;
    logic [15:0] span;
    r.stepped = 1'b0;
    if (tick && mode_r != MODE_OFF) begin
      span     = (mode_r == MODE_BLINK) ? blink_iv : fade_iv;
      next_cnt = {1'b0, tick_cnt} + 17'd1;
      if (next_cnt > {1'b0, COUNT_MAX}) next_cnt = {1'b0, COUNT_MAX};
      if (next_cnt >= {1'b0, span}) begin
        tick_cnt  = '0;
        r.stepped = 1'b1;
        if (mode_r == MODE_BLINK) begin
          eye      = blink_ph ? EYE_BLUE : EYE_GREEN;
          blink_ph = ~blink_ph;
        end else begin
          advance_fade(mode_r == MODE_FADE_EYE);
        end
      end else begin
        tick_cnt = next_cnt[15:0];
      end
    end
    r.red_level   = level[0];
    r.green_level = level[1];
    r.blue_level  = level[2];
    r.eye_color   = eye;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Results are compared before new input is predicted on the same edge
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    result_t fresh;
    if (!rst_n) begin
      clear_state();
      levels_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_red_level, out_green_level, out_blue_level, out_eye_color, out_stepped};
        if (levels_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual r %0d g %0d b %0d eye %0d st %0d",
                   $time, got.red_level, got.green_level, got.blue_level, got.eye_color,
                   got.stepped);
        end else begin
          want = levels_due.pop_front();
          check_field("red_level", int'(want.red_level), int'(got.red_level));
          check_field("green_level", int'(want.green_level), int'(got.green_level));
          check_field("blue_level", int'(want.blue_level), int'(got.blue_level));
          check_field("eye_color", int'(want.eye_color), int'(got.eye_color));
          check_field("stepped", int'(want.stepped), int'(got.stepped));
        end
      end
      if (cfg_we) write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        take_tick(in_tick, fresh);
        levels_due.push_back(fresh);
      end
    end
    pending <= levels_due.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top for the RGB fade/blink sequencer: clock, reset, stimulus, stalls, verdict.
`timescale 1ns / 100ps
module testbench;
  import rlfb_pkg::*;

  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int         IDLE_LIMIT   = 1000;
  localparam int         RANDOM_TICKS = 750;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_tick;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_red_level;
  logic [9:0]  out_green_level;
  logic [9:0]  out_blue_level;
  logic [1:0]  out_eye_color;
  logic        out_stepped;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int          fail_count;
  int          pending;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  rgb_log_fade_blink_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_tick(in_tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red_level(out_red_level), .out_green_level(out_green_level),
    .out_blue_level(out_blue_level), .out_eye_color(out_eye_color),
    .out_stepped(out_stepped),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fade_blink_checker level_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_tick(in_tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red_level(out_red_level), .out_green_level(out_green_level),
    .out_blue_level(out_blue_level), .out_eye_color(out_eye_color),
    .out_stepped(out_stepped),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: after each accepted transaction, stall for a random number of cycles
  always @(posedge clk) begin : result_sink
    int hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (out_valid && !out_stall) begin
      hold = rx_calm ? 0 : $urandom_range(0, 16);
      stall_left <= hold;
      out_stall  <= (hold > 0);
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one tick/idle transaction after a random gap; valid stays high on return
  task automatic send_tick(input logic t);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Mostly short intervals so steps come often; now and then the extremes
  function automatic logic [15:0] pick_interval(input int typical_max);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return COUNT_MAX;
    if (sel == 1) return 16'($urandom);
    return 16'($urandom_range(0, typical_max));
  endfunction

  function automatic logic [1:0] draw_mode();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 2) return MODE_OFF;
    if (sel < 6) return MODE_BLINK;
    if (sel < 13) return MODE_FADE_EYE;
    return MODE_FADE;
  endfunction

  initial begin : stimulus
    int          counted;
    int          burst;
    int          tick_pct;
    logic        t;
    logic [1:0]  cur_mode;
    logic [15:0] word;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_tick   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // mode off after reset: ticks ignored
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();

    // blink every second tick, first tick steps at once
    cfg_write(REG_BLINK_INTERVAL, 16'd2);
    cfg_write(REG_MODE, {14'd0, MODE_BLINK});
    cfg_we <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();

    // zero fade interval: a step on every tick
    cfg_write(REG_FADE_INTERVAL, 16'd0);
    cfg_write(REG_MODE, {14'd0, MODE_FADE_EYE});
    cfg_we <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();

    // full-scale interval: saturated count fires once, then nothing
    cfg_write(REG_FADE_INTERVAL, COUNT_MAX);
    cfg_write(REG_MODE, {14'h3FFF, MODE_FADE});
    cfg_we <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();

    // unused register index, then off again: eye off, levels held
    cfg_write(REG_UNUSED, 16'hFFFF);
    cfg_write(REG_MODE, {14'd0, MODE_OFF});
    cfg_we <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    // random phases, each with its own settings, tick density and idling
    cur_mode = MODE_OFF;
    counted  = 0;
    while (counted < RANDOM_TICKS) begin
      if ($urandom_range(0, 4) != 0) cfg_write(REG_FADE_INTERVAL, pick_interval(2));
      if ($urandom_range(0, 3) == 0) cfg_write(REG_BLINK_INTERVAL, pick_interval(5));
      if ($urandom_range(0, 9) == 0) cfg_write(REG_UNUSED, 16'($urandom));
      if ($urandom_range(0, 4) != 0) begin
        cur_mode  = draw_mode();
        word      = 16'($urandom);
        word[1:0] = cur_mode;
        cfg_write(REG_MODE, word);
      end
      cfg_we <= 1'b0;
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);
      burst    = $urandom_range(20, 80);
      tick_pct = ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(60, 100);
      repeat (burst) begin
        t = ($urandom_range(1, 100) <= tick_pct);
        send_tick(t);
        counted++;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rlfb_pkg.sv
rtl/rlfb_fade.sv
rtl/rlfb_core.sv
rtl/rgb_log_fade_blink_sequencer.sv
tb/sv/fade_blink_checker.sv
tb/sv/testbench.sv
